[rtl/iabst_pkg.sv]
// Shared types and constants for the implicit-array binary search tree table.
// No dependencies; every other file imports this package.
`default_nettype none
package iabst_pkg;

    // Default number of tree levels; slots 1 .. 2**levels - 1 exist.
    localparam int TREE_LEVELS_DEF = 6;

    // Operation codes of a request.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // One request as it arrives at the block.
    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] item_key;
        logic signed [31:0] item_value;
    } t_request;

    // One result as it leaves the block.
    typedef struct packed {
        logic [1:0] status;
        logic       tree_empty;
    } t_result;

    // One memory entry: the key and value of a slot.
    typedef struct packed {
        logic signed [31:0] key;
        logic signed [31:0] value;
    } t_entry;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_WALK,
        S_CMP,
        S_REM,
        S_SUCC,
        S_SUCC_WR,
        S_SIMPLE,
        S_LIFT,
        S_LIFT_WR,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

[rtl/iabst_mem.sv]
// Key/value slot memory: one write port, one read port, registered read data.
// Depends on iabst_pkg for the entry type.
`default_nettype none
module iabst_mem
    import iabst_pkg::*;
#(
    parameter int ADDR_W = TREE_LEVELS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire t_entry            i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output t_entry                 o_rdata
);

    t_entry r_mem [2**ADDR_W];
    t_entry r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[rtl/iabst_ctrl.sv]
// Sequencer for insert, search and remove, including the slot occupancy bits.
// Depends on iabst_pkg; drives the ports of iabst_mem.
`default_nettype none
module iabst_ctrl
    import iabst_pkg::*;
#(
    parameter int TREE_LEVELS = TREE_LEVELS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    input  wire t_request               i_request,
    output logic                        busy,
    output logic                        o_done,
    output t_result                     o_result,
    output logic                        o_mem_we,
    output logic [TREE_LEVELS-1:0]      o_mem_waddr,
    output t_entry                      o_mem_wdata,
    output logic [TREE_LEVELS-1:0]      o_mem_raddr,
    input  wire t_entry                 i_mem_rdata
);

    localparam int L     = TREE_LEVELS;
    localparam int SLOTS = 2**L;

    t_state r_state, n_state;
    logic [1:0]              r_op;
    logic signed [31:0]      r_key, r_val;
    logic [L:0]              r_idx, n_idx;
    logic [L:0]              r_succ, n_succ;
    logic [L:0]              r_base, n_base;
    logic [L:0]              r_src, n_src;
    logic [L:0]              r_span, n_span;
    logic [L-1:0]            r_j, n_j;
    logic [1:0]              r_status, n_status;
    logic [SLOTS-1:0]        r_used, n_used;

    logic [L:0] left_c, right_c, succ_left, dst, src;
    logic       left_p, right_p, succ_left_p, idx_p, key_eq, key_lt, last_j;

    // A slot exists and is occupied.
    function automatic logic present(input logic [L:0] x, input logic [SLOTS-1:0] used);
        return !x[L] && used[x[L-1:0]];
    endfunction

    // Neighbor slots, comparisons and copy addresses used by the next-state and datapath blocks.
    assign left_c      = {r_idx[L-1:0], 1'b0};
    assign right_c     = {r_idx[L-1:0], 1'b1};
    assign succ_left   = {r_succ[L-1:0], 1'b0};
    assign left_p      = present(left_c, r_used);
    assign right_p     = present(right_c, r_used);
    assign succ_left_p = present(succ_left, r_used);
    assign idx_p       = present(r_idx, r_used);
    assign key_eq      = (i_mem_rdata.key == r_key);
    assign key_lt      = (r_key < i_mem_rdata.key);
    assign dst         = r_base + {1'b0, r_j};
    assign src         = r_src + {1'b0, r_j};
    assign last_j      = ({1'b0, r_j} == (r_span - 1'b1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_request.opcode inside {OP_INSERT, OP_REMOVE, OP_SEARCH}) begin
                        n_state = S_WALK;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_WALK:    n_state = idx_p ? S_CMP : S_DONE;
            S_CMP: begin
                if (r_op != OP_INSERT && key_eq) begin
                    n_state = (r_op == OP_REMOVE) ? S_REM : S_DONE;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_REM:     n_state = (left_p && right_p) ? S_SUCC : S_SIMPLE;
            S_SUCC:    n_state = succ_left_p ? S_SUCC : S_SUCC_WR;
            S_SUCC_WR: n_state = S_SIMPLE;
            S_SIMPLE:  n_state = (left_p || right_p) ? S_LIFT : S_DONE;
            S_LIFT: begin
                if (r_base[L]) begin
                    n_state = S_DONE;
                end else if (r_base[L:L-1] == 2'b00) begin
                    n_state = S_LIFT_WR;
                end
            end
            S_LIFT_WR: n_state = S_LIFT;
            S_DONE:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Datapath, memory requests and occupancy updates.
    always_comb begin
        n_idx       = r_idx;
        n_succ      = r_succ;
        n_base      = r_base;
        n_src       = r_src;
        n_span      = r_span;
        n_j         = r_j;
        n_status    = r_status;
        n_used      = r_used;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_idx[L-1:0];
        o_mem_wdata = '{key: r_key, value: r_val};
        o_mem_raddr = r_idx[L-1:0];
        case (r_state)
            S_IDLE: begin
                n_idx    = {{L{1'b0}}, 1'b1};
                n_status = ST_OK;
            end
            S_WALK: begin
                if (!idx_p) begin
                    if (r_op == OP_INSERT) begin
                        if (r_idx[L]) begin
                            n_status = ST_FULL;
                        end else begin
                            o_mem_we             = 1'b1;
                            n_used[r_idx[L-1:0]] = 1'b1;
                        end
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                end
            end
            S_CMP: begin
                if (r_op == OP_INSERT || !key_eq) begin
                    n_idx = key_lt ? left_c : right_c;
                end
            end
            S_REM: begin
                n_succ = right_c;
            end
            S_SUCC: begin
                o_mem_raddr = r_succ[L-1:0];
                if (succ_left_p) begin
                    n_succ = succ_left;
                end
            end
            S_SUCC_WR: begin
                o_mem_we    = 1'b1;
                o_mem_wdata = i_mem_rdata;
                n_idx       = r_succ;
            end
            S_SIMPLE: begin
                n_base = r_idx;
                n_src  = left_p ? left_c : right_c;
                n_span = {{L{1'b0}}, 1'b1};
                n_j    = '0;
                if (!left_p && !right_p) begin
                    n_used[r_idx[L-1:0]] = 1'b0;
                end
            end
            S_LIFT: begin
                o_mem_raddr = src[L-1:0];
                // Deepest level of the subtree is cleared one slot a cycle.
                if (!r_base[L] && r_base[L:L-1] != 2'b00) begin
                    n_used[dst[L-1:0]] = 1'b0;
                    if (last_j) begin
                        n_j    = '0;
                        n_base = {r_base[L-1:0], 1'b0};
                        n_src  = {r_src[L-1:0], 1'b0};
                        n_span = {r_span[L-1:0], 1'b0};
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end
            end
            S_LIFT_WR: begin
                o_mem_we           = 1'b1;
                o_mem_waddr        = dst[L-1:0];
                o_mem_wdata        = i_mem_rdata;
                n_used[dst[L-1:0]] = r_used[src[L-1:0]];
                if (last_j) begin
                    n_j    = '0;
                    n_base = {r_base[L-1:0], 1'b0};
                    n_src  = {r_src[L-1:0], 1'b0};
                    n_span = {r_span[L-1:0], 1'b0};
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            default: begin
            end
        endcase
        n_used[0] = 1'b0;
    end

    // Control state and occupancy bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
        end
    end

    // Request payload and walk registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_op  <= i_request.opcode;
            r_key <= i_request.item_key;
            r_val <= i_request.item_value;
        end
        r_idx    <= n_idx;
        r_succ   <= n_succ;
        r_base   <= n_base;
        r_src    <= n_src;
        r_span   <= n_span;
        r_j      <= n_j;
        r_status <= n_status;
    end

    assign busy                = (r_state != S_IDLE);
    assign o_done              = (r_state == S_DONE);
    assign o_result.status     = r_status;
    assign o_result.tree_empty = !r_used[1];

`ifndef SYNTH
    a_slot0_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n) !r_used[0])
        else $error("slot zero marked used");
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but sequencer idle");
    a_done_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> (r_state == S_IDLE))
        else $error("done lasted more than one cycle");
    a_lift_in_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIFT_WR) |-> ({1'b0, r_j} < r_span))
        else $error("subtree copy ran past its level");
`endif

endmodule
`default_nettype wire

[rtl/implicit_array_bst_table_unit.sv]
// Search and insert walk the tree level by level from the root. Removal, for a node with two
// children, steps down to the successor and copies it; it then lifts the subtree below,
// relocating each entry, clearing each slot of its deepest level and closing the move.
// One request at a time; busy drops in the cycle that shows the result strobe.
// Result is registered and shown for one cycle on o_done; the receiver cannot stall.
// Reset (synchronous, active low) empties the tree at once; no clearing pass is needed.
// Top level: slot memory, sequencer and result register. Depends on iabst_pkg.
`default_nettype none
module implicit_array_bst_table_unit
    import iabst_pkg::*;
#(
    parameter int TREE_LEVELS = TREE_LEVELS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    input  wire t_request i_request,
    output logic          busy,
    output logic          o_done,
    output t_result       o_result
);

    logic                   mem_we;
    logic [TREE_LEVELS-1:0] mem_waddr, mem_raddr;
    t_entry                 mem_wdata, mem_rdata;
    logic                   done;
    t_result                result;
    logic                   r_done;
    t_result                r_result;

    iabst_mem #(.ADDR_W(TREE_LEVELS)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    iabst_ctrl #(.TREE_LEVELS(TREE_LEVELS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_request   (i_request),
        .busy        (busy),
        .o_done      (done),
        .o_result    (result),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_result <= result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
`default_nettype wire
